>>> hdl/gtr_pkg.sv
// Package for the glyph text rasterizer: sizes, codes, payload types and the
// command and status groups between controller and datapath. No dependencies.
`default_nettype none
package gtr_pkg;

    localparam int BITMAP_BYTES   = 8192;
    localparam int GLYPH_ENTRIES  = 256;
    localparam int MAX_GLYPH_SIZE = 32;
    localparam int SCREEN_WIDTH   = 320;
    localparam int SCREEN_HEIGHT  = 240;
    localparam int GLYPH_LIMIT    = (MAX_GLYPH_SIZE < 32) ? MAX_GLYPH_SIZE : 32;
    localparam int BM_AW          = $clog2(BITMAP_BYTES);
    localparam int GT_AW          = $clog2(GLYPH_ENTRIES);
    localparam int FETCH_BYTES    = 5;

    localparam logic [1:0] CMD_BITMAP = 2'd0;
    localparam logic [1:0] CMD_GLYPH  = 2'd1;
    localparam logic [1:0] CMD_ORIGIN = 2'd2;
    localparam logic [1:0] CMD_CHAR   = 2'd3;

    localparam logic [7:0] CODE_NONE    = 8'd0;
    localparam logic [7:0] CODE_NEWLINE = 8'd10;

    localparam logic [1:0] REG_FIRST_CODE   = 2'd0;
    localparam logic [1:0] REG_LINE_ADVANCE = 2'd1;
    localparam logic [1:0] REG_FONT_COLOUR  = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [12:0] address;
        logic [7:0]  data_byte;
        logic [12:0] glyph_bitmap_offset;
        logic [5:0]  glyph_width;
        logic [5:0]  glyph_height;
        logic [7:0]  glyph_x_advance;
        logic signed [7:0] glyph_x_offset;
        logic signed [7:0] glyph_y_offset;
        logic [15:0] origin_x;
        logic [15:0] origin_y;
    } t_in_req;

    typedef struct packed {
        logic [9:0]  row_y;
        logic [15:0] start_x;
        logic [31:0] pixel_mask;
        logic [15:0] colour;
        logic        last_row;
    } t_out_req;

    typedef struct packed {
        logic [12:0] offset;
        logic [5:0]  width;
        logic [5:0]  height;
        logic [7:0]  x_advance;
        logic [7:0]  x_shift;
        logic [7:0]  y_shift;
    } t_glyph_rec;

    typedef struct packed {
        logic       accept;
        logic       load_rec;
        logic       fetch_en;
        logic [2:0] fetch_k;
        logic       take_row;
        logic       next_row;
        logic       flush;
        logic       adv_x;
    } t_cmd;

    typedef struct packed {
        logic start_glyph;
        logic row_done;
        logic row_off;
        logic mask_nz;
        logic pend_valid;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

>>> hdl/glyph_text_rasterizer.sv
// Top level of the glyph text rasterizer: controller, datapath and checks.
// Depends on gtr_pkg, gtr_ctrl and gtr_dp.
//
// Load, origin, newline and ignored character requests are each taken while the
// controller is idle. A drawable character reads its glyph record, then makes a
// row check for each glyph row: a row that falls outside the screen is skipped,
// and a visible row takes single-byte reads of the bitmap RAM port and mask
// assembly. A flush step closes the character; a full output can hold a row back
// in mask assembly or in the flush step until the output is free again. The
// last row waits in a one-row hold register so that last_row is known; rows
// leave through an output register, so a character may start while the final
// row of the previous one still waits.
`default_nettype none
module glyph_text_rasterizer (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire gtr_pkg::t_in_req  i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output gtr_pkg::t_out_req      o_out_data,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [15:0]       i_cfg_wdata
);
    import gtr_pkg::*;

    t_cmd    cmd;
    t_status status;

    gtr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    gtr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !status.pend_valid)
        else $error("held row left over while idle");

    a_glyph_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && status.start_glyph) |=> !o_in_ready)
        else $error("ready after drawable character");

    a_mask_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.pixel_mask != 32'd0))
        else $error("empty row emitted");

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((cmd.take_row || cmd.flush) && status.pend_valid) |-> status.out_free)
        else $error("row pushed over a waiting result");
endmodule
`default_nettype wire

>>> hdl/gtr_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module gtr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

>>> hdl/gtr_ctrl.sv
// Controller of the glyph text rasterizer: sequences record read, row fetch,
// row emission and flush. Depends on gtr_pkg.
`default_nettype none
module gtr_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire gtr_pkg::t_status i_status,
    output gtr_pkg::t_cmd         o_cmd
);
    import gtr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_REC, S_ROW, S_FETCH, S_MASK, S_FLUSH
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_k, n_k;
    t_cmd       cmd;

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                cmd.accept = i_in_valid;
                if (i_in_valid && i_status.start_glyph) begin
                    n_state = S_REC;
                end
            end
            S_REC: begin
                cmd.load_rec = 1'b1;
                n_state      = S_ROW;
            end
            S_ROW: begin
                if (i_status.row_done) begin
                    n_state = S_FLUSH;
                end else if (i_status.row_off) begin
                    cmd.next_row = 1'b1;
                end else begin
                    n_k     = 3'd0;
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                cmd.fetch_en = 1'b1;
                cmd.fetch_k  = r_k;
                n_k          = r_k + 3'd1;
                if (r_k == 3'(FETCH_BYTES)) begin
                    n_state = S_MASK;
                end
            end
            S_MASK: begin
                if (!i_status.mask_nz) begin
                    cmd.next_row = 1'b1;
                    n_state      = S_ROW;
                end else if (!i_status.pend_valid || i_status.out_free) begin
                    cmd.take_row = 1'b1;
                    cmd.next_row = 1'b1;
                    n_state      = S_ROW;
                end
            end
            S_FLUSH: begin
                if (!i_status.pend_valid || i_status.out_free) begin
                    cmd.flush = 1'b1;
                    cmd.adv_x = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= 3'd0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = cmd;
endmodule
`default_nettype wire

>>> hdl/gtr_dp.sv
// Datapath of the glyph text rasterizer: registers, cursor, font stores, row
// assembly and output register. Depends on gtr_pkg and gtr_ram.
`default_nettype none
module gtr_dp (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire gtr_pkg::t_in_req  i_in_data,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [15:0]       i_cfg_wdata,
    input  wire gtr_pkg::t_cmd     i_cmd,
    output gtr_pkg::t_status       o_status,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output gtr_pkg::t_out_req      o_out_data
);
    import gtr_pkg::*;

    logic [7:0]  r_first, r_ladv;
    logic [15:0] r_colour, r_cx, r_cy, r_hx;
    t_glyph_rec  r_glyph;
    logic [31:0] r_xmask;
    logic [15:0] r_py;
    logic [5:0]  r_row;
    logic [10:0] r_bitpos;
    logic [8*FETCH_BYTES-1:0] r_buf;
    logic        r_pend_v;
    logic [9:0]  r_pend_y;
    logic [31:0] r_pend_mask;
    logic        r_ov;
    t_out_req    r_out;

    logic [7:0]  idx;
    logic        idx_ok, start_glyph, bm_we, gt_we, push, out_free;
    t_glyph_rec  wr_rec, rd_rec;
    logic [7:0]  bm_rdata;
    logic [BM_AW:0] fetch_sum;
    logic [8*FETCH_BYTES-1:0] shifted;
    logic [31:0] mask, xmask;
    logic [5:0]  w_hold, h_hold;
    logic [15:0] yo_ext;

    assign idx    = i_in_data.data_byte - r_first;
    assign idx_ok = ({1'b0, idx} < 9'(GLYPH_ENTRIES));
    assign start_glyph = (i_in_data.command == CMD_CHAR)
                       && (i_in_data.data_byte != CODE_NONE)
                       && (i_in_data.data_byte != CODE_NEWLINE)
                       && (i_in_data.data_byte >= r_first) && idx_ok;

    assign bm_we = i_cmd.accept && (i_in_data.command == CMD_BITMAP)
                && ({4'd0, i_in_data.address} < 17'(BITMAP_BYTES));
    assign gt_we = i_cmd.accept && (i_in_data.command == CMD_GLYPH)
                && ({4'd0, i_in_data.address} < 17'(GLYPH_ENTRIES));

    assign w_hold = (i_in_data.glyph_width > 6'(GLYPH_LIMIT)) ? 6'(GLYPH_LIMIT)
                                                              : i_in_data.glyph_width;
    assign h_hold = (i_in_data.glyph_height > 6'(GLYPH_LIMIT)) ? 6'(GLYPH_LIMIT)
                                                               : i_in_data.glyph_height;
    assign wr_rec = '{offset: i_in_data.glyph_bitmap_offset, width: w_hold,
                      height: h_hold, x_advance: i_in_data.glyph_x_advance,
                      x_shift: i_in_data.glyph_x_offset,
                      y_shift: i_in_data.glyph_y_offset};

    assign fetch_sum = (BM_AW+1)'(r_glyph.offset) + (BM_AW+1)'(r_bitpos[10:3])
                     + (BM_AW+1)'(i_cmd.fetch_k);

    gtr_ram #(.WIDTH(8), .DEPTH(BITMAP_BYTES)) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_waddr (i_in_data.address[BM_AW-1:0]),
        .i_wdata (i_in_data.data_byte),
        .i_raddr (fetch_sum[BM_AW-1:0]),
        .o_rdata (bm_rdata)
    );

    gtr_ram #(.WIDTH($bits(t_glyph_rec)), .DEPTH(GLYPH_ENTRIES)) u_glyphs (
        .i_clk   (i_clk),
        .i_we    (gt_we),
        .i_waddr (i_in_data.address[GT_AW-1:0]),
        .i_wdata (wr_rec),
        .i_raddr (idx[GT_AW-1:0]),
        .o_rdata (rd_rec)
    );

    assign yo_ext = {{8{rd_rec.y_shift[7]}}, rd_rec.y_shift};

    always_comb begin
        for (int c = 0; c < 32; c++) begin
            xmask[c] = (6'(c) < rd_rec.width)
                    && ((r_cx + 16'(c)) < 16'(SCREEN_WIDTH));
        end
    end

    assign shifted = r_buf << r_bitpos[2:0];
    always_comb begin
        for (int c = 0; c < 32; c++) begin
            mask[c] = shifted[8*FETCH_BYTES-1-c] & r_xmask[c];
        end
    end

    assign out_free = !r_ov || i_out_ready;
    assign push     = (i_cmd.take_row || i_cmd.flush) && r_pend_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first  <= 8'd32;
            r_ladv   <= 8'd8;
            r_colour <= 16'hFFFF;
            r_cx     <= '0;
            r_cy     <= '0;
            r_hx     <= '0;
            r_pend_v <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_FIRST_CODE:   r_first  <= i_cfg_wdata[7:0];
                    REG_LINE_ADVANCE: r_ladv   <= i_cfg_wdata[7:0];
                    REG_FONT_COLOUR:  r_colour <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_cmd.accept && i_in_data.command == CMD_ORIGIN) begin
                r_cx <= i_in_data.origin_x;
                r_hx <= i_in_data.origin_x;
                r_cy <= i_in_data.origin_y;
            end
            if (i_cmd.accept && i_in_data.command == CMD_CHAR
                && i_in_data.data_byte == CODE_NEWLINE) begin
                r_cy <= r_cy - 16'(r_ladv);
                r_cx <= r_hx;
            end
            if (i_cmd.adv_x) begin
                r_cx <= r_cx + 16'(r_glyph.x_advance);
            end
            if (i_cmd.take_row) begin
                r_pend_v <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend_v <= 1'b0;
            end
            if (push) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_rec) begin
            r_glyph  <= rd_rec;
            r_xmask  <= xmask;
            r_py     <= r_cy - yo_ext - 16'd1;
            r_row    <= '0;
            r_bitpos <= '0;
        end
        if (i_cmd.next_row) begin
            r_row    <= r_row + 6'd1;
            r_py     <= r_py - 16'd1;
            r_bitpos <= r_bitpos + 11'(r_glyph.width);
        end
        if (i_cmd.fetch_en && i_cmd.fetch_k != 3'd0) begin
            r_buf <= {r_buf[8*FETCH_BYTES-9:0], bm_rdata};
        end
        if (i_cmd.take_row) begin
            r_pend_y    <= r_py[9:0];
            r_pend_mask <= mask;
        end
        if (push) begin
            r_out <= '{row_y: r_pend_y, start_x: r_cx, pixel_mask: r_pend_mask,
                       colour: r_colour, last_row: i_cmd.flush};
        end
    end

    assign o_status = '{start_glyph: start_glyph, row_done: (r_row == r_glyph.height),
                        row_off: (r_py >= 16'(SCREEN_HEIGHT)), mask_nz: (mask != '0),
                        pend_valid: r_pend_v, out_free: out_free};
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;
endmodule
`default_nettype wire

>>> test/glyph_text_rasterizer_tb.sv
// Testbench for the glyph text rasterizer: predicts every visible, non-empty pixel
// row of each drawn character and checks it against the block's output stream.
// Depends on gtr_pkg and glyph_text_rasterizer.
`timescale 1ns / 100ps
module glyph_text_rasterizer_tb;
    import gtr_pkg::*;

    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int FONT_BYTES_USED = 64;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_req     i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_req    o_out_data;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_wdata;

    glyph_text_rasterizer uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_wdata(i_cfg_wdata)
    );

    // predictor state
    logic [7:0]  font_bytes [BITMAP_BYTES];
    t_glyph_rec  glyph_recs [GLYPH_ENTRIES];
    logic [15:0] pen_x, pen_y, margin_x;
    logic [7:0]  cfg_first_code, cfg_line_advance;
    logic [15:0] cfg_colour;

    t_in_req  pending_reqs [$];
    t_out_req expected_rows [$];
    int       error_count;
    int       rows_seen;
    int       chars_drawn;
    bit       no_idle;
    bit       send_pause;
    int       hold_off;
    int       watchdog;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void rasterize_request(input t_in_req r);
        t_glyph_rec  g;
        logic [15:0] base_y, py, px;
        logic [31:0] mask;
        int          bitn, idx, first_new, n;
        logic [7:0]  hs;
        case (r.command)
            CMD_BITMAP: font_bytes[r.address] = r.data_byte;
            CMD_GLYPH: begin
                if (r.address < GLYPH_ENTRIES) begin
                    g.offset    = r.glyph_bitmap_offset;
                    g.width     = (r.glyph_width > GLYPH_LIMIT) ? 6'(GLYPH_LIMIT)
                                                                : r.glyph_width;
                    g.height    = (r.glyph_height > GLYPH_LIMIT) ? 6'(GLYPH_LIMIT)
                                                                 : r.glyph_height;
                    g.x_advance = r.glyph_x_advance;
                    g.x_shift   = r.glyph_x_offset;
                    g.y_shift   = r.glyph_y_offset;
                    glyph_recs[r.address] = g;
                end
            end
            CMD_ORIGIN: begin
                pen_x = r.origin_x;
                margin_x = r.origin_x;
                pen_y = r.origin_y;
            end
            default: begin
                if (r.data_byte == CODE_NEWLINE) begin
                    pen_y = pen_y - 16'(cfg_line_advance);
                    pen_x = margin_x;
                end else if (r.data_byte != CODE_NONE && r.data_byte >= cfg_first_code)
                begin
                    idx = int'(r.data_byte) - int'(cfg_first_code);
                    g = glyph_recs[idx];
                    base_y = pen_y - 16'(g.height) - {{8{g.y_shift[7]}}, g.y_shift};
                    first_new = expected_rows.size();
                    n = 0;
                    for (int row = 0; row < g.height; row++) begin
                        py = base_y + 16'(g.height) - 16'd1 - 16'(row);
                        if (py >= SCREEN_HEIGHT) continue;
                        mask = '0;
                        for (int c = 0; c < g.width; c++) begin
                            bitn = row * g.width + c;
                            px = pen_x + 16'(c);
                            hs = font_bytes[(g.offset + (bitn >> 3)) % BITMAP_BYTES];
                            if (hs[7 - (bitn & 7)] && px < SCREEN_WIDTH) mask[c] = 1'b1;
                        end
                        if (mask == '0) continue;
                        expected_rows.push_back('{py[9:0], pen_x, mask, cfg_colour, 1'b0});
                        n++;
                    end
                    if (n > 0) expected_rows[first_new + n - 1].last_row = 1'b1;
                    pen_x = pen_x + 16'(g.x_advance);
                    chars_drawn++;
                end
            end
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (i_in_valid) rasterize_request(i_in_data);
            if (pending_reqs.size() > 0 && !send_pause &&
                (no_idle || $urandom_range(99) >= 29)) begin
                i_in_data  <= pending_reqs.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                rows_seen++;
                if (expected_rows.size() == 0) begin
                    $display("%0t: unexpected row %p", $time, o_out_data);
                    error_count++;
                end else if (expected_rows[0] !== o_out_data) begin
                    $display("%0t: row mismatch, expected %p, actual %p",
                             $time, expected_rows[0], o_out_data);
                    error_count++;
                    void'(expected_rows.pop_front());
                end else begin
                    void'(expected_rows.pop_front());
                end
            end
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= no_idle || $urandom_range(99) >= 29;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            watchdog <= 0;
        else if (watchdog >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else
            watchdog <= watchdog + 1;
    end

    function automatic t_in_req blank_req(input logic [1:0] cmd);
        t_in_req r;
        r = '0;
        r.command = cmd;
        return r;
    endfunction

    function automatic t_in_req glyph_req(input int idx, input int off, input int w,
                                          input int h, input int adv, input int yo);
        t_in_req r;
        r = blank_req(CMD_GLYPH);
        r.address = 13'(idx);
        r.glyph_bitmap_offset = 13'(off);
        r.glyph_width = 6'(w);
        r.glyph_height = 6'(h);
        r.glyph_x_advance = 8'(adv);
        r.glyph_x_offset = 8'($urandom);
        r.glyph_y_offset = 8'(yo);
        return r;
    endfunction

    // random glyph whose bits stay inside the written font bytes
    function automatic t_in_req rand_glyph(input int idx);
        int w, h, hw, hh, nbytes;
        w = $urandom_range(63);
        h = $urandom_range(63);
        hw = (w > GLYPH_LIMIT) ? GLYPH_LIMIT : w;
        if (hw > 0 && h > (8 * FONT_BYTES_USED) / hw) h = (8 * FONT_BYTES_USED) / hw;
        hh = (h > GLYPH_LIMIT) ? GLYPH_LIMIT : h;
        nbytes = (hw * hh + 7) / 8;
        return glyph_req(idx, $urandom_range(FONT_BYTES_USED - nbytes), w, h,
                         $urandom, $urandom);
    endfunction

    function automatic t_in_req char_req(input logic [7:0] code);
        t_in_req r;
        r = blank_req(CMD_CHAR);
        r.data_byte = code;
        r.address = 13'($urandom);
        return r;
    endfunction

    function automatic t_in_req origin_req(input logic [15:0] x, input logic [15:0] y);
        t_in_req r;
        r = blank_req(CMD_ORIGIN);
        r.origin_x = x;
        r.origin_y = y;
        return r;
    endfunction

    task automatic wait_drained();
        send_pause = 1'b1;
        while (i_in_valid) @(posedge i_clk);
        while (expected_rows.size() > 0) @(posedge i_clk);
        send_pause = 1'b0;
        while (pending_reqs.size() > 0 || i_in_valid) @(posedge i_clk);
        while (expected_rows.size() > 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            REG_FIRST_CODE:   cfg_first_code   = val[7:0];
            REG_LINE_ADVANCE: cfg_line_advance = val[7:0];
            default:          cfg_colour       = val;
        endcase
    endtask

    // character from written glyph set, a newline, or random code that is safely ignored
    function automatic t_in_req random_char();
        int idx;
        if ($urandom_range(9) == 0) return char_req(CODE_NEWLINE);
        if ($urandom_range(14) == 0) return char_req(CODE_NONE);
        if (cfg_first_code > 0 && $urandom_range(9) == 0)
            return char_req(8'($urandom_range(cfg_first_code - 1)));
        idx = $urandom_range(15);
        if (int'(cfg_first_code) + idx > 255) return char_req(CODE_NEWLINE);
        return char_req(8'(int'(cfg_first_code) + idx));
    endfunction

    initial begin
        t_in_req r;
        error_count = 0;
        rows_seen = 0;
        chars_drawn = 0;
        no_idle = 1'b0;
        send_pause = 1'b0;
        hold_off = 0;
        watchdog = 0;
        pen_x = '0; pen_y = '0; margin_x = '0;
        cfg_first_code = 8'd32; cfg_line_advance = 8'd8; cfg_colour = 16'hFFFF;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_FIRST_CODE;
        i_cfg_wdata = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // font bytes at the bottom of the store; every random glyph stays inside them
        send_pause = 1'b1;
        for (int a = 0; a < FONT_BYTES_USED; a++) begin
            r = blank_req(CMD_BITMAP);
            r.address = 13'(a);
            r.data_byte = (a < 8) ? 8'hFF : 8'($urandom);
            r.glyph_bitmap_offset = 13'($urandom);
            r.origin_x = 16'($urandom);
            r.origin_y = 16'($urandom);
            pending_reqs.push_back(r);
        end
        // glyph entries that later characters reach
        for (int g = 0; g < 16; g++)
            pending_reqs.push_back(rand_glyph(g));
        pending_reqs.push_back(rand_glyph(223));
        pending_reqs.push_back(rand_glyph(255));
        no_idle = 1'b1;
        send_pause = 1'b0;
        wait_drained();
        no_idle = 1'b0;

        // directed: extremes of size, offsets, clipping and wrap
        pending_reqs.push_back(glyph_req(0, 0, 63, 16, 255, 127));
        pending_reqs.push_back(glyph_req(1, 8191, 8, 63, 0, -128));
        pending_reqs.push_back(glyph_req(2, 0, 0, 0, 7, 0));
        pending_reqs.push_back(glyph_req(3, 0, 8, 8, 8, 0));
        r = blank_req(CMD_BITMAP); r.address = 13'd8191; r.data_byte = 8'hA5;
        pending_reqs.push_back(r);
        pending_reqs.push_back(origin_req(16'd0, 16'd100));
        pending_reqs.push_back(char_req(8'd32));
        pending_reqs.push_back(char_req(8'd33));
        pending_reqs.push_back(char_req(8'd34));
        pending_reqs.push_back(char_req(CODE_NEWLINE));
        pending_reqs.push_back(char_req(CODE_NONE));
        pending_reqs.push_back(char_req(8'd31));
        pending_reqs.push_back(char_req(8'd255));
        pending_reqs.push_back(origin_req(16'd316, 16'd239));
        pending_reqs.push_back(char_req(8'd35));
        pending_reqs.push_back(origin_req(16'hFFFC, 16'hFFFF));
        pending_reqs.push_back(char_req(8'd35));
        pending_reqs.push_back(char_req(8'd33));
        pending_reqs.push_back(origin_req(16'hFFFF, 16'd5));
        pending_reqs.push_back(char_req(CODE_NEWLINE));
        pending_reqs.push_back(char_req(8'd35));
        wait_drained();
        write_reg(REG_FIRST_CODE, 16'd0);
        write_reg(REG_LINE_ADVANCE, 16'd255);
        write_reg(REG_FONT_COLOUR, 16'h0000);
        pending_reqs.push_back(origin_req(16'd10, 16'd20));
        pending_reqs.push_back(char_req(8'd3));
        pending_reqs.push_back(char_req(8'd255));
        pending_reqs.push_back(char_req(CODE_NEWLINE));
        pending_reqs.push_back(char_req(8'd1));

        // random phases with varied settings
        for (int phase = 0; phase < 4; phase++) begin
            wait_drained();
            case (phase)
                0: begin
                    write_reg(REG_FIRST_CODE, 16'd240);
                    write_reg(REG_LINE_ADVANCE, 16'd0);
                    write_reg(REG_FONT_COLOUR, 16'($urandom));
                end
                1: begin
                    write_reg(REG_FIRST_CODE, 16'd32);
                    write_reg(REG_LINE_ADVANCE, 16'd8);
                    write_reg(REG_FONT_COLOUR, 16'hFFFF);
                end
                default: begin
                    write_reg(REG_FIRST_CODE, 16'($urandom_range(20, 200)));
                    write_reg(REG_LINE_ADVANCE, 16'($urandom_range(255)));
                    write_reg(REG_FONT_COLOUR, 16'($urandom));
                end
            endcase
            no_idle = (phase == 1);
            for (int k = 0; k < 28; k++) begin
                case ($urandom_range(9))
                    0: pending_reqs.push_back(origin_req(16'($urandom_range(330)),
                                                         16'($urandom_range(250))));
                    1: pending_reqs.push_back(rand_glyph($urandom_range(15)));
                    2: begin
                        r = blank_req(CMD_BITMAP);
                        r.address = 13'($urandom);
                        r.data_byte = 8'($urandom);
                        pending_reqs.push_back(r);
                    end
                    default: pending_reqs.push_back(random_char());
                endcase
            end
            if (phase == 2) begin
                // long receiver stall while requests keep coming
                hold_off = 600;
                while (hold_off > 0) @(posedge i_clk);
            end
        end
        send_pause = 1'b0;
        while (pending_reqs.size() > 0 || i_in_valid) @(posedge i_clk);
        while (expected_rows.size() > 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        $display("Run covered %0d drawn characters and %0d pixel rows over six settings.",
                 chars_drawn, rows_seen);
        if (error_count == 0 && expected_rows.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
